[sv/mfab_pkg.sv]
// Package for the mesh face adjacency builder.
// Holds widths, the edge table entry layout, result and status codes and the edge hash.
// No dependencies.
package mfab_pkg;

  localparam int VW        = 16;
  localparam int FW        = 16;
  localparam int VC_W      = 17;
  localparam int TBL_AW    = 17;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int OCC_W     = TBL_AW + 1;

  localparam logic [VC_W-1:0] VC_RESET  = VC_W'(65536);
  localparam logic [1:0]      SLOT_LAST = 2'd2;

  typedef enum logic [1:0] {
    STAT_ADJ  = 2'd0,
    STAT_REP  = 2'd1,
    STAT_FULL = 2'd2,
    STAT_OOR  = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_PROBE,
    ST_HIT2,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic          valid;
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    logic [FW-1:0] face;
    logic [1:0]    slot;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  typedef struct packed {
    logic [FW-1:0] face;
    logic [1:0]    slot;
    logic [FW-1:0] nb;
    stat_t         status;
  } res_t;

  typedef struct packed {
    logic [VW-1:0] vmin;
    logic [VW-1:0] vmid;
    logic [VW-1:0] vmax;
    logic          oor;
    logic          rep;
  } srt_t;

  function automatic logic [TBL_AW-1:0] hash_edge(input logic [VW-1:0] lo,
                                                  input logic [VW-1:0] hi);
    logic [TBL_AW:0] sum;
    sum = {2'b00, lo} + {1'b0, hi, 1'b0};
    return sum[TBL_AW-1:0];
  endfunction

endpackage

[sv/mesh_face_adjacency_builder_top.sv]
// Mesh face adjacency builder: edge table controller and result staging.
// Depends on mfab_pkg, mfab_sorter and mfab_edge_ram.
//
// Use: a triangle is taken on in_vertex_a/b/c when start is high and busy
// is low; its face number is the count of triangles since reset, wrapping
// at 65536. Results come out on the out_ ports, at most one word per
// cycle, each marked by out_strobe for exactly one cycle; out_last_result
// marks the final word of a face. The receiver cannot stall the block.
// vertex_count is written on cfg_data when cfg_valid is high (cfg_ready is
// always high); write it only while busy is low: the block does not enforce
// this. After reset the block clears all 131072 entries of the edge table,
// one entry per cycle, with busy high, before it takes the first triangle.
// A flagged triangle goes from idle straight to the close state. A good one,
// for each of its edges in turn (vmin-vmid, vmin-vmax, vmid-vmax), issues
// the hash address and then probes the linear-probed table, with a further
// step that returns the second result on a shared edge; then it closes and
// returns to idle to take the next triangle. The single table port sets the
// rate; on a full table with no match it probes the whole table per edge.
module mesh_face_adjacency_builder_top
  import mfab_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  logic [VW-1:0]   in_vertex_a,
  input  logic [VW-1:0]   in_vertex_b,
  input  logic [VW-1:0]   in_vertex_c,
  output logic            out_strobe,
  output logic [FW-1:0]   out_target_face,
  output logic [1:0]      out_edge_slot,
  output logic [FW-1:0]   out_neighbour_face,
  output logic [1:0]      out_status,
  output logic            out_last_result,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [VC_W-1:0] cfg_data
);

  state_t            state_r, state_nxt;
  logic [VC_W-1:0]   vcount_r;
  logic [FW-1:0]     face_r, face_nxt, cur_face_r, cur_face_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [VW-1:0]     vmin_r, vmid_r, vmax_r, vmin_nxt, vmid_nxt, vmax_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [TBL_AW-1:0] paddr_r, paddr_nxt, pcnt_r, pcnt_nxt, clr_r, clr_nxt;
  res_t              pend_r, pend_nxt, hit2_r, hit2_nxt, push_res, out_r, out_nxt;
  logic              pend_v_r, pend_v_nxt, push_en, flush;
  logic              ostb_r, ostb_nxt, olast_r, olast_nxt;

  srt_t              srt;
  logic [TBL_AW-1:0] ram_addr;
  logic              ram_we;
  entry_t            ram_wdata, ent;
  logic [ENT_W-1:0]  ram_rdata;
  logic [VW-1:0]     key_lo, key_hi;
  logic              slot_end;

  mfab_sorter u_sorter (
    .va           (in_vertex_a),
    .vb           (in_vertex_b),
    .vc           (in_vertex_c),
    .vertex_count (vcount_r),
    .srt          (srt)
  );

  mfab_edge_ram #(.AW(TBL_AW), .DW(ENT_W)) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ent       = entry_t'(ram_rdata);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    case (slot_r)
      2'd0:    begin key_lo = vmin_r; key_hi = vmid_r; end
      2'd1:    begin key_lo = vmin_r; key_hi = vmax_r; end
      default: begin key_lo = vmid_r; key_hi = vmax_r; end
    endcase
  end

  always_comb begin
    state_nxt    = state_r;
    face_nxt     = face_r;
    cur_face_nxt = cur_face_r;
    occ_nxt      = occ_r;
    vmin_nxt     = vmin_r;
    vmid_nxt     = vmid_r;
    vmax_nxt     = vmax_r;
    slot_nxt     = slot_r;
    paddr_nxt    = paddr_r;
    pcnt_nxt     = pcnt_r;
    clr_nxt      = clr_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    hit2_nxt     = hit2_r;
    out_nxt      = out_r;
    ostb_nxt     = 1'b0;
    olast_nxt    = 1'b0;
    push_en      = 1'b0;
    push_res     = '0;
    flush        = 1'b0;
    slot_end     = 1'b0;
    ram_addr     = paddr_r;
    ram_we       = 1'b0;
    ram_wdata    = '0;

    case (state_r)
      ST_CLEAR: begin
        ram_addr = clr_r;
        ram_we   = 1'b1;
        clr_nxt  = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cur_face_nxt = face_r;
          face_nxt     = face_r + 1'b1;
          vmin_nxt     = srt.vmin;
          vmid_nxt     = srt.vmid;
          vmax_nxt     = srt.vmax;
          slot_nxt     = 2'd0;
          if (srt.oor || srt.rep) begin
            push_en         = 1'b1;
            push_res.face   = face_r;
            push_res.status = srt.oor ? STAT_OOR : STAT_REP;
            state_nxt       = ST_DONE;
          end else begin
            state_nxt = ST_ISSUE;
          end
        end
      end
      ST_ISSUE: begin
        ram_addr  = hash_edge(key_lo, key_hi);
        paddr_nxt = ram_addr;
        pcnt_nxt  = '0;
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (ent.valid && ent.lo == key_lo && ent.hi == key_hi) begin
          push_en        = 1'b1;
          push_res.face  = cur_face_r;
          push_res.slot  = slot_r;
          push_res.nb    = ent.face;
          hit2_nxt       = '0;
          hit2_nxt.face  = ent.face;
          hit2_nxt.slot  = ent.slot;
          hit2_nxt.nb    = cur_face_r;
          state_nxt      = ST_HIT2;
        end else if (!ent.valid) begin
          ram_we          = 1'b1;
          ram_wdata.valid = 1'b1;
          ram_wdata.lo    = key_lo;
          ram_wdata.hi    = key_hi;
          ram_wdata.face  = cur_face_r;
          ram_wdata.slot  = slot_r;
          occ_nxt         = occ_r + 1'b1;
          slot_end        = 1'b1;
        end else if (&pcnt_r) begin
          push_en         = 1'b1;
          push_res.face   = cur_face_r;
          push_res.slot   = slot_r;
          push_res.status = STAT_FULL;
          slot_end        = 1'b1;
        end else begin
          ram_addr  = paddr_r + 1'b1;
          paddr_nxt = ram_addr;
          pcnt_nxt  = pcnt_r + 1'b1;
        end
      end
      ST_HIT2: begin
        push_en  = 1'b1;
        push_res = hit2_r;
        slot_end = 1'b1;
      end
      ST_DONE: begin
        flush     = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (slot_end) begin
      if (slot_r == SLOT_LAST) begin
        state_nxt = ST_DONE;
      end else begin
        slot_nxt  = slot_r + 1'b1;
        state_nxt = ST_ISSUE;
      end
    end

    if (push_en) begin
      if (pend_v_r) begin
        out_nxt  = pend_r;
        ostb_nxt = 1'b1;
      end
      pend_nxt   = push_res;
      pend_v_nxt = 1'b1;
    end

    if (flush && pend_v_r) begin
      out_nxt    = pend_r;
      ostb_nxt   = 1'b1;
      olast_nxt  = 1'b1;
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      vcount_r <= VC_RESET;
      face_r   <= '0;
      occ_r    <= '0;
      clr_r    <= '0;
      pend_v_r <= 1'b0;
      ostb_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      face_r   <= face_nxt;
      occ_r    <= occ_nxt;
      clr_r    <= clr_nxt;
      pend_v_r <= pend_v_nxt;
      ostb_r   <= ostb_nxt;
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_face_r <= cur_face_nxt;
    vmin_r     <= vmin_nxt;
    vmid_r     <= vmid_nxt;
    vmax_r     <= vmax_nxt;
    slot_r     <= slot_nxt;
    paddr_r    <= paddr_nxt;
    pcnt_r     <= pcnt_nxt;
    pend_r     <= pend_nxt;
    hit2_r     <= hit2_nxt;
    out_r      <= out_nxt;
    olast_r    <= olast_nxt;
  end

  assign out_strobe         = ostb_r;
  assign out_target_face    = out_r.face;
  assign out_edge_slot      = out_r.slot;
  assign out_neighbour_face = out_r.nb;
  assign out_status         = out_r.status;
  assign out_last_result    = olast_r;

endmodule

[sv/mfab_edge_ram.sv]
// Single-port synchronous RAM for the edge table, registered read data.
// Generic; no package dependency.
module mfab_edge_ram #(
  parameter int AW = 17,
  parameter int DW = 51
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  input  logic          we,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[sv/mfab_sorter.sv]
// Vertex sort and triangle checks: range against vertex_count, repeated vertex.
// Depends on mfab_pkg.
module mfab_sorter
  import mfab_pkg::*;
(
  input  logic [VW-1:0]   va,
  input  logic [VW-1:0]   vb,
  input  logic [VW-1:0]   vc,
  input  logic [VC_W-1:0] vertex_count,
  output srt_t            srt
);

  logic [VW-1:0] a1, b1, b2, c2, a3, b3;

  always_comb begin
    a1 = (va > vb) ? vb : va;
    b1 = (va > vb) ? va : vb;
    b2 = (b1 > vc) ? vc : b1;
    c2 = (b1 > vc) ? b1 : vc;
    a3 = (a1 > b2) ? b2 : a1;
    b3 = (a1 > b2) ? a1 : b2;
    srt.vmin = a3;
    srt.vmid = b3;
    srt.vmax = c2;
    srt.oor  = ({1'b0, va} >= vertex_count) || ({1'b0, vb} >= vertex_count) ||
               ({1'b0, vc} >= vertex_count);
    srt.rep  = (va == vb) || (va == vc) || (vb == vc);
  end

endmodule

[sv/mfab_checker.sv]
// Port-level checks for the mesh face adjacency builder, bound to the top level.
// Depends on mfab_pkg.
module mfab_checker
  import mfab_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input logic [1:0]    out_edge_slot,
  input logic [FW-1:0] out_neighbour_face,
  input logic [1:0]    out_status,
  input logic          out_last_result
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  a_flag_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status == STAT_REP || out_status == STAT_OOR) |->
      out_last_result && out_neighbour_face == '0 && out_edge_slot == 2'd0)
    else $error("flagged face word malformed");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_edge_slot != 2'd3)
    else $error("edge slot out of range");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result word after reset");

endmodule

bind mesh_face_adjacency_builder_top mfab_checker u_mfab_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_strobe         (out_strobe),
  .out_edge_slot      (out_edge_slot),
  .out_neighbour_face (out_neighbour_face),
  .out_status         (out_status),
  .out_last_result    (out_last_result)
);
